// File: rtl/pol_pkg.sv
package pol_pkg;

  localparam int POL_CAP_DEF = 32;
  localparam int POL_CAP_MAX = 64;
  // cell select field covers the largest supported chain
  localparam int POL_SEL_W   = $clog2(POL_CAP_MAX);

  localparam int POL_VAL_W = 32;
  localparam int POL_ACT_W = 3;
  localparam int POL_POS_W = 7;
  localparam int POL_ST_W  = 2;
  localparam int POL_CNT_W = 7;

  typedef enum logic [POL_ACT_W-1:0] {
    ACT_INS_FIRST = 3'd0,
    ACT_INS_LAST  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FIRST = 3'd3,
    ACT_DEL_LAST  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_LIST      = 3'd6,
    ACT_COUNT     = 3'd7
  } pol_act_t;

  localparam logic [POL_ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [POL_ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [POL_ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [POL_ST_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } pol_state_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    COP_HOLD = 2'd0,
    COP_INS  = 2'd1,
    COP_DEL  = 2'd2,
    COP_ROT  = 2'd3
  } pol_cop_t;

  typedef struct packed {
    pol_cop_t               op;
    logic [POL_SEL_W-1:0]   sel;
  } pol_cell_ctl_t;

endpackage

// File: rtl/pol_cell.sv
module pol_cell import pol_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  pol_cell_ctl_t         ctl,
  input  logic [POL_VAL_W-1:0]  ins_value,
  input  logic [POL_VAL_W-1:0]  head_value,
  input  logic [POL_VAL_W-1:0]  left_value,
  input  logic [POL_VAL_W-1:0]  right_value,
  output logic [POL_VAL_W-1:0]  value
);

  localparam logic [POL_SEL_W-1:0] MY_IDX = POL_SEL_W'(IDX);

  logic [POL_VAL_W-1:0] val_r;
  logic [POL_VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      COP_INS: begin
        if (MY_IDX > ctl.sel) val_nxt = left_value;
        else if (MY_IDX == ctl.sel) val_nxt = ins_value;
      end
      COP_DEL: begin
        if (MY_IDX >= ctl.sel) val_nxt = right_value;
      end
      COP_ROT: begin
        // sel is the last held cell; the head wraps around into it
        if (MY_IDX < ctl.sel) val_nxt = right_value;
        else if (MY_IDX == ctl.sel) val_nxt = head_value;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value = val_r;

endmodule

// File: rtl/positional_ordered_list.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | action, value, position
// out_    | output    | out_valid/out_stall | status, entry_total, has_value,
//         |           |                     | entry_value, entry_index, last
//
// Insert, delete and count: one beat out per request.
// List: one beat per held entry (one beat when empty); the chain rotates by one
// cell per beat, and no new request is taken until the last beat leaves.
// A stalled output beat holds the chain and blocks new requests until it leaves.
// rst_n (sync, active low) empties the list; cell contents are not cleared.
module positional_ordered_list import pol_pkg::*; #(
  parameter int CAPACITY = POL_CAP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POL_ACT_W-1:0]  in_action,
  input  logic [POL_VAL_W-1:0]  in_value,
  input  logic [POL_POS_W-1:0]  in_position,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POL_ST_W-1:0]   out_status,
  output logic [POL_CNT_W-1:0]  out_entry_total,
  output logic                  out_has_value,
  output logic [POL_VAL_W-1:0]  out_entry_value,
  output logic [POL_CNT_W-1:0]  out_entry_index,
  output logic                  out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [POL_VAL_W-1:0] cell_val [CAPACITY];
  pol_cell_ctl_t        ctl;

  pol_state_t           state_r, state_nxt;
  logic [CW-1:0]        held_r, held_nxt;
  logic [CW-1:0]        lidx_r, lidx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [POL_ST_W-1:0]  status_r, status_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic                 hv_r, hv_nxt;
  logic [POL_VAL_W-1:0] eval_r, eval_nxt;
  logic [CW-1:0]        eidx_r, eidx_nxt;
  logic                 last_r, last_nxt;

  logic                 out_free, accept, load;
  logic [7:0]           pos8, held8;
  logic                 ins_ok, del_ok, full, empty;
  pol_act_t             act;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      pol_cell #(.IDX(g)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .ins_value   (in_value),
        .head_value  (cell_val[0]),
        .left_value  ((g > 0) ? cell_val[(g > 0) ? g - 1 : 0] : in_value),
        .right_value (cell_val[(g < CAPACITY - 1) ? g + 1 : g]),
        .value       (cell_val[g])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign act   = pol_act_t'(in_action);
  assign pos8  = 8'(in_position);
  assign held8 = 8'(held_r);
  assign full  = (held_r == CW'(CAPACITY));
  assign empty = (held_r == '0);
  assign ins_ok = (in_position != '0) && (pos8 <= held8 + 8'd1);
  assign del_ok = (in_position != '0) && (pos8 <= held8);

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    lidx_nxt   = lidx_r;
    ctl.op     = COP_HOLD;
    ctl.sel    = '0;
    load       = 1'b0;
    status_nxt = ST_DONE;
    total_nxt  = held_r;
    hv_nxt     = 1'b0;
    eval_nxt   = '0;
    eidx_nxt   = '0;
    last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (act)
            ACT_INS_FIRST, ACT_INS_LAST, ACT_INS_AT: begin
              if (act == ACT_INS_AT && !ins_ok) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.op = COP_INS;
                if (act == ACT_INS_FIRST) ctl.sel = '0;
                else if (act == ACT_INS_LAST) ctl.sel = POL_SEL_W'(held_r);
                else ctl.sel = POL_SEL_W'(in_position - POL_POS_W'(1));
                held_nxt  = held_r + CW'(1);
                total_nxt = held_nxt;
              end
            end
            ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (act == ACT_DEL_AT && !del_ok) begin
                status_nxt = ST_RANGE;
              end else begin
                ctl.op = COP_DEL;
                if (act == ACT_DEL_FIRST) ctl.sel = '0;
                else if (act == ACT_DEL_LAST) ctl.sel = POL_SEL_W'(held_r - CW'(1));
                else ctl.sel = POL_SEL_W'(in_position - POL_POS_W'(1));
                held_nxt  = held_r - CW'(1);
                total_nxt = held_nxt;
              end
            end
            ACT_LIST: begin
              if (!empty) begin
                load      = 1'b0;
                state_nxt = S_LIST;
                lidx_nxt  = CW'(1);
              end
            end
            ACT_COUNT: ;
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          load     = 1'b1;
          ctl.op   = COP_ROT;
          ctl.sel  = POL_SEL_W'(held_r - CW'(1));
          hv_nxt   = 1'b1;
          eval_nxt = cell_val[0];
          eidx_nxt = lidx_r;
          last_nxt = (lidx_r == held_r);
          lidx_nxt = lidx_r + CW'(1);
          if (lidx_r == held_r) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      lidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      lidx_r      <= lidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      total_r  <= total_nxt;
      hv_r     <= hv_nxt;
      eval_r   <= eval_nxt;
      eidx_r   <= eidx_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_total = POL_CNT_W'(total_r);
  assign out_has_value   = hv_r;
  assign out_entry_value = eval_r;
  assign out_entry_index = POL_CNT_W'(eidx_r);
  assign out_last        = last_r;

endmodule

// File: rtl/pol_checker.sv
module pol_checker import pol_pkg::*; #(
  parameter int CAPACITY = POL_CAP_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [POL_ST_W-1:0]   out_status,
  input logic [POL_CNT_W-1:0]  out_entry_total,
  input logic                  out_has_value,
  input logic [POL_VAL_W-1:0]  out_entry_value,
  input logic [POL_CNT_W-1:0]  out_entry_index,
  input logic                  out_last
);

  // a beat without an entry carries zero value and index and ends its request
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_value |->
      out_entry_value == '0 && out_entry_index == '0 && out_last)
    else $error("beat without entry has payload or is not last");

  // listed entries are always successful and indexed within the count
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_value |->
      out_status == ST_DONE && out_entry_index != '0 &&
      out_entry_index <= out_entry_total)
    else $error("listed entry has bad status or index");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= POL_CNT_W'(CAPACITY))
    else $error("entry total above capacity");

  // within a list, consecutive beats count up by one
  a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_has_value && !out_last ##1 out_valid |->
      out_has_value && out_entry_index == $past(out_entry_index) + 7'd1)
    else $error("list beats out of order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_value))
    else $error("stalled beat dropped or changed");

endmodule

bind positional_ordered_list pol_checker #(.CAPACITY(CAPACITY)) u_pol_checker (.*);
